// ===== sv/boca_pkg.sv =====
`default_nettype none
package boca_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] BYTE_ONES = 8'hff;

	typedef enum logic [1:0] {
		REG_SRC_OFFSET = 2'd0,
		REG_DST_OFFSET = 2'd1,
		REG_BIT_LENGTH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] src_pos;
		logic [2:0] dst_pos;
	} offset_cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] mask;
		logic       last;
	} result_t;

	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} result_pair_t;

endpackage
`default_nettype wire

// ===== sv/boca_front.sv =====
`default_nettype none
module boca_front #(
	parameter int LENGTH_BITS = boca_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire boca_pkg::offset_cfg_t     offsets,
	input  wire logic [LENGTH_BITS-1:0]    bit_length,
	input  wire logic                      cfg_clear,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [7:0]                s_tdata,
	input  wire logic                      q_full,
	output logic                           q_push,
	output boca_pkg::result_pair_t         q_pair
);
	import boca_pkg::*;

	logic [14:0]            bit_carry_q;
	logic [3:0]             carry_fill_q;
	logic [LENGTH_BITS-1:0] bits_left_q;
	logic                   first_pending_q;

	logic                   accept, start, skip;
	logic [3:0]             avail, n, cf, cf2, cf3;
	logic [7:0]             byte_m, bits;
	logic [LENGTH_BITS-1:0] bl, bl2;
	logic [14:0]            bc, bc2, bc3;
	logic                   fp, fp3;
	logic                   emit0, emit1;
	logic [2:0]             sh, lead0, lead1;
	result_t                res0, res1;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign start    = (bits_left_q == '0);
	assign skip     = start && (bit_length == '0);

	always_comb begin
		avail  = start ? (4'd8 - {1'b0, offsets.src_pos}) : 4'd8;
		byte_m = start ? (s_tdata & (BYTE_ONES >> offsets.src_pos)) : s_tdata;
		bl     = start ? bit_length : bits_left_q;
		cf     = start ? {1'b0, offsets.dst_pos} : carry_fill_q;
		bc     = start ? '0 : bit_carry_q;
		fp     = start ? 1'b1 : first_pending_q;

		n    = (bl < LENGTH_BITS'(avail)) ? bl[3:0] : avail;
		bits = byte_m >> (avail - n);
		bc2  = 15'((bc << n) | 15'(bits));
		cf2  = cf + n;
		bl2  = bl - LENGTH_BITS'(n);

		emit0 = (cf2 >= 4'd8);
		sh    = 3'(cf2 - 4'd8);
		lead0 = fp ? offsets.dst_pos : 3'd0;
		res0.mask = BYTE_ONES >> lead0;
		res0.data = 8'(bc2 >> sh) & res0.mask;
		res0.last = (bl2 == '0) && (sh == 3'd0);

		cf3 = emit0 ? {1'b0, sh} : cf2;
		bc3 = emit0 ? (bc2 & ((15'd1 << sh) - 15'd1)) : bc2;
		fp3 = emit0 ? 1'b0 : fp;

		emit1 = (bl2 == '0) && (cf3 != 4'd0);
		lead1 = fp3 ? offsets.dst_pos : 3'd0;
		res1.mask = (BYTE_ONES >> lead1) & 8'(BYTE_ONES << (4'd8 - cf3));
		res1.data = 8'(bc3 << (4'd8 - cf3)) & res1.mask;
		res1.last = 1'b1;

		if (emit0) begin
			q_pair.two = emit1;
			q_pair.r0  = res0;
		end else begin
			q_pair.two = 1'b0;
			q_pair.r0  = res1;
		end
		q_pair.r1 = res1;
		q_push    = accept && !skip && (emit0 || emit1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_carry_q     <= '0;
			carry_fill_q    <= '0;
			bits_left_q     <= '0;
			first_pending_q <= 1'b1;
		end else if (cfg_clear || (accept && !skip && bl2 == '0)) begin
			bit_carry_q     <= '0;
			carry_fill_q    <= '0;
			bits_left_q     <= '0;
			first_pending_q <= 1'b1;
		end else if (accept && !skip) begin
			bit_carry_q     <= bc3;
			carry_fill_q    <= cf3;
			bits_left_q     <= bl2;
			first_pending_q <= fp3;
		end
	end

endmodule
`default_nettype wire

// ===== sv/boca_queue.sv =====
`default_nettype none
module boca_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire boca_pkg::result_pair_t push_pair,
	output logic                        full,
	input  wire logic                   pop,
	output logic                        head_valid,
	output boca_pkg::result_pair_t      head_pair
);
	import boca_pkg::*;

	result_pair_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_pair  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/boca_back.sv =====
`default_nettype none
module boca_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   head_valid,
	input  wire boca_pkg::result_pair_t head_pair,
	output logic                        pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [15:0]                 m_tdata,
	output logic                        m_tlast
);
	import boca_pkg::*;

	logic    second_q;
	logic    m_tvalid_q;
	result_t out_q;
	result_t slot;
	logic    load;

	assign slot = second_q ? head_pair.r1 : head_pair.r0;
	assign load = head_valid && (!m_tvalid_q || m_tready);
	assign pop  = load && !(head_pair.two && !second_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.mask, out_q.data};
	assign m_tlast  = out_q.last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				second_q   <= head_pair.two && !second_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/bit_offset_copy_aligner.sv =====
// Bit-granular copy realigner.
// Source bytes enter on the s_ stream, one per item, starting with the byte
// that holds the first source bit (bits numbered MSB first). Destination
// bytes leave on the m_ stream with a per-bit write mask in m_tdata[15:8];
// m_tlast marks the final byte of the copy.
// Program src/dst bit offsets and bit length over APB while idle; any write
// to a defined register drops a copy in progress. Each run begins with the
// next source byte after the previous run ended.
// A result reaches m_ through the queue and then the output register.
// Throughput: one source item per cycle while the queue is not full; the
// output stage gives one result per cycle while m_tready is high, so the
// final item of a run that yields two results presents them one after
// the other. A four-entry queue between the classifier and the output
// stage absorbs that and short receiver stalls.
// When m_tready is low, the output holds and the queue fills; s_tready drops
// once the queue is full.
// Reset clears the run state and queue; registers return to offsets 0 and
// length 1.
`default_nettype none
module bit_offset_copy_aligner #(
	parameter int LENGTH_BITS = boca_pkg::LENGTH_BITS_DEF,
	localparam int CfgDw      = (LENGTH_BITS > 32) ? 64 : 32,
	localparam int AddrLsb    = (CfgDw == 64) ? 3 : 2,
	localparam int PaddrW     = AddrLsb + 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [PaddrW-1:0] paddr,
	input  wire logic [CfgDw-1:0]  pwdata,
	output logic [CfgDw-1:0]       prdata,
	output logic                   pready,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [7:0] src_byte
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata,   // [7:0] dst_byte, [15:8] write_mask
	output logic                   m_tlast
);
	import boca_pkg::*;

	offset_cfg_t            offsets_q;
	logic [LENGTH_BITS-1:0] bit_length_q;
	logic                   wr_en, cfg_clear;
	reg_idx_t               reg_idx;
	logic                   q_full, q_push, q_pop, head_valid;
	result_pair_t           q_pair, head_pair;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[PaddrW-1:AddrLsb]);

	always_comb begin
		cfg_clear = 1'b0;
		prdata    = '0;
		unique case (reg_idx)
			REG_SRC_OFFSET: begin
				cfg_clear = wr_en;
				prdata    = CfgDw'(offsets_q.src_pos);
			end
			REG_DST_OFFSET: begin
				cfg_clear = wr_en;
				prdata    = CfgDw'(offsets_q.dst_pos);
			end
			REG_BIT_LENGTH: begin
				cfg_clear = wr_en;
				prdata    = CfgDw'(bit_length_q);
			end
			default: begin
				cfg_clear = 1'b0;
				prdata    = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offsets_q    <= '0;
			bit_length_q <= LENGTH_BITS'(1);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SRC_OFFSET: offsets_q.src_pos <= pwdata[2:0];
				REG_DST_OFFSET: offsets_q.dst_pos <= pwdata[2:0];
				REG_BIT_LENGTH: bit_length_q      <= pwdata[LENGTH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	boca_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.offsets   (offsets_q),
		.bit_length(bit_length_q),
		.cfg_clear (cfg_clear),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_pair    (q_pair)
	);

	boca_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_pair (q_pair),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(head_valid),
		.head_pair (head_pair)
	);

	boca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_pair (head_pair),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// ===== sv/boca_checker.sv =====
`default_nettype none
module boca_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:8] != 8'h00)
		else $error("empty write mask");

	a_data_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] & ~m_tdata[15:8]) == 8'h00)
		else $error("data bits outside write mask");

	a_inner_full_tail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[8])
		else $error("non-final byte does not reach its last bit");

endmodule

bind bit_offset_copy_aligner boca_checker u_boca_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
`default_nettype wire
